/* rtl/lsb_pkg.sv */
// Package with widths, reset values and codes of the link supervisor.
package lsb_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0] RetryInitialRst = 32'd1000;
  localparam logic [TimeW-1:0] RetryMaxRst     = 32'd60000;
  localparam logic [TimeW-1:0] RebootAfterRst  = 32'd1800000;
  localparam logic [TimeW-1:0] RadioResetRst   = 32'd300000;

  typedef logic [TimeW-1:0] time_ms_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RETRY   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_REBOOT  = 2'd3
  } action_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RETRY_INITIAL = 2'd0,
    CFG_RETRY_MAX     = 2'd1,
    CFG_REBOOT_AFTER  = 2'd2,
    CFG_RADIO_RESET   = 2'd3
  } cfg_reg_t;

endpackage

/* rtl/lsb_poll_if.sv */
// Channel interfaces for poll beats and result beats of the link supervisor.
interface lsb_poll_if;
  import lsb_pkg::*;

  logic     valid;
  logic     ready;
  time_ms_t now_ms;
  logic     link_up;
  logic     session_up;

  modport source (output valid, output now_ms, output link_up, output session_up,
                  input ready);
  modport sink (input valid, input now_ms, input link_up, input session_up,
                output ready);
endinterface

interface lsb_result_if;
  import lsb_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  logic    link_outage;
  logic    session_outage;

  modport source (output valid, output action, output link_outage,
                  output session_outage, input ready);
  modport sink (input valid, input action, input link_outage, input session_outage,
                output ready);
endinterface

/* rtl/link_supervisor_backoff.sv */
// Top level of the link supervisor with exponential reconnect backoff.
// The block takes one poll beat per clock cycle unless stalled and returns exactly one
// result beat for each: the poll is captured in an input register, and when that register
// advances the supervisor state and the result register are updated together, so the
// update of the outage, deadline and delay registers sets the rate. A full result
// register that is not taken stalls the input register, and polls keep flowing while
// both registers can advance.
module link_supervisor_backoff (
  input  logic                             clk,
  input  logic                             rst_n,
  lsb_poll_if.sink                         in_if,
  lsb_result_if.source                     out_if,
  input  logic                             cfg_we,
  input  logic [lsb_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [lsb_pkg::TimeW-1:0]        cfg_data
);
  import lsb_pkg::*;

  time_ms_t retry_initial_r, retry_max_r, reboot_after_r, radio_reset_r;

  logic     s1_valid_r;
  time_ms_t s1_now_r;
  logic     s1_link_r, s1_session_r;

  logic     out_valid_r;
  action_t  out_action_r;
  logic     out_lo_r, out_so_r;

  logic     link_act_r, link_act_nxt;
  time_ms_t link_start_r, link_start_nxt;
  logic     sess_act_r, sess_act_nxt;
  time_ms_t sess_start_r, sess_start_nxt;
  time_ms_t next_att_r, next_att_nxt;
  time_ms_t delay_r, delay_nxt;
  time_ms_t last_radio_r, last_radio_nxt;
  action_t  action_nxt;

  logic     advance;
  time_ms_t link_start_eff, next_att_eff, delay_eff, last_radio_eff, sess_start_eff;
  time_ms_t link_age, sess_age, radio_age, due_diff;
  logic     restart;
  logic [TimeW:0] doubled;
  time_ms_t delay_grown;

  assign advance      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || advance;

  assign out_if.valid          = out_valid_r;
  assign out_if.action         = out_action_r;
  assign out_if.link_outage    = out_lo_r;
  assign out_if.session_outage = out_so_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_initial_r <= RetryInitialRst;
      retry_max_r     <= RetryMaxRst;
      reboot_after_r  <= RebootAfterRst;
      radio_reset_r   <= RadioResetRst;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RETRY_INITIAL: retry_initial_r <= cfg_data;
        CFG_RETRY_MAX:     retry_max_r     <= cfg_data;
        CFG_REBOOT_AFTER:  reboot_after_r  <= cfg_data;
        CFG_RADIO_RESET:   radio_reset_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Values seen by the current poll once a new outage has been opened.
  always_comb begin
    link_start_eff = link_act_r ? link_start_r : s1_now_r;
    next_att_eff   = link_act_r ? next_att_r : s1_now_r;
    delay_eff      = link_act_r ? delay_r : retry_initial_r;
    last_radio_eff = link_act_r ? s1_now_r : last_radio_r;
    sess_start_eff = sess_act_r ? sess_start_r : s1_now_r;
    link_age       = s1_now_r - link_start_eff;
    sess_age       = s1_now_r - sess_start_eff;
    due_diff       = s1_now_r - next_att_eff;
    radio_age      = s1_now_r - (s1_link_r ? last_radio_eff : last_radio_r);
    restart        = radio_age >= radio_reset_r;
    doubled        = {delay_eff, 1'b0};
    delay_grown    = (doubled < {1'b0, retry_max_r}) ? doubled[TimeW-1:0] : retry_max_r;
  end

  always_comb begin
    link_act_nxt   = link_act_r;
    link_start_nxt = link_start_r;
    sess_act_nxt   = sess_act_r;
    sess_start_nxt = sess_start_r;
    next_att_nxt   = next_att_r;
    delay_nxt      = delay_r;
    last_radio_nxt = last_radio_r;
    action_nxt     = ACT_NONE;
    if (!s1_link_r) begin
      link_act_nxt   = 1'b1;
      link_start_nxt = link_start_eff;
      next_att_nxt   = next_att_eff;
      delay_nxt      = delay_eff;
      if (link_age >= reboot_after_r) begin
        action_nxt = ACT_REBOOT;
      end else if (restart || !due_diff[TimeW-1]) begin
        if (restart) begin
          last_radio_nxt = s1_now_r;
        end
        next_att_nxt = s1_now_r + delay_eff;
        delay_nxt    = delay_grown;
        action_nxt   = restart ? ACT_RESTART : ACT_RETRY;
      end
    end else begin
      if (link_act_r) begin
        link_act_nxt   = 1'b0;
        delay_nxt      = retry_initial_r;
        next_att_nxt   = '0;
        last_radio_nxt = s1_now_r;
      end
      if (s1_session_r) begin
        sess_act_nxt = 1'b0;
      end else begin
        sess_act_nxt   = 1'b1;
        sess_start_nxt = sess_start_eff;
        if (sess_age >= reboot_after_r) begin
          action_nxt = ACT_REBOOT;
        end else if (restart) begin
          last_radio_nxt = s1_now_r;
          link_act_nxt   = 1'b1;
          link_start_nxt = s1_now_r;
          next_att_nxt   = s1_now_r + retry_initial_r;
          delay_nxt      = retry_initial_r;
          action_nxt     = ACT_RESTART;
        end
      end
    end
    // A reboot request returns the supervisor to its reset state, but with the configured initial retry delay.
    if (action_nxt == ACT_REBOOT) begin
      link_act_nxt   = 1'b0;
      link_start_nxt = '0;
      sess_act_nxt   = 1'b0;
      sess_start_nxt = '0;
      next_att_nxt   = '0;
      delay_nxt      = retry_initial_r;
      last_radio_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_act_r   <= 1'b0;
      link_start_r <= '0;
      sess_act_r   <= 1'b0;
      sess_start_r <= '0;
      next_att_r   <= '0;
      delay_r      <= RetryInitialRst;
      last_radio_r <= '0;
    end else if (advance) begin
      link_act_r   <= link_act_nxt;
      link_start_r <= link_start_nxt;
      sess_act_r   <= sess_act_nxt;
      sess_start_r <= sess_start_nxt;
      next_att_r   <= next_att_nxt;
      delay_r      <= delay_nxt;
      last_radio_r <= last_radio_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_now_r     <= in_if.now_ms;
      s1_link_r    <= in_if.link_up;
      s1_session_r <= in_if.session_up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_action_r <= action_nxt;
      out_lo_r     <= link_act_nxt;
      out_so_r     <= sess_act_nxt;
    end
  end

endmodule
